### rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INS_REAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJ_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJ_EMPTY = 2'd2;

  typedef struct packed {
    logic load_req;
    logic do_write;
    logic do_read;
    logic upd_ptr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic empty;
  } sts_t;

endpackage

### rtl/cdq_ram.sv
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  cdq_pkg::sts_t sts,
  output cdq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_insert) begin
          if (out_free) begin
            cmd.do_write = !sts.full;
            cmd.upd_ptr  = !sts.full;
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (sts.empty) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.do_read = 1'b1;
          state_next  = S_RDATA;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          cmd.upd_ptr  = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/cdq_dp.sv
module cdq_dp #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdq_pkg::cmd_t                     cmd,
  output cdq_pkg::sts_t                     sts,
  input  logic [cdq_pkg::REQ_W-1:0]         req_type,
  input  logic signed [cdq_pkg::WORD_W-1:0] value,
  output logic [cdq_pkg::STAT_W-1:0]        status,
  output logic signed [cdq_pkg::WORD_W-1:0] removed_value,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [cdq_pkg::REQ_W-1:0]  req_r;
  logic [cdq_pkg::WORD_W-1:0] value_r;
  logic [AW-1:0]              head;
  logic [AW-1:0]              tail;
  logic                       empty;

  logic                       ins;
  logic                       front;
  logic                       full;
  logic                       succ;
  logic [AW-1:0]              head_next;
  logic [AW-1:0]              tail_next;
  logic                       empty_next;
  logic [AW-1:0]              head_eff;
  logic [AW-1:0]              tail_eff;
  logic                       empty_eff;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [cdq_pkg::WORD_W-1:0] rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  assign ins   = (req_r == cdq_pkg::REQ_INS_FRONT) || (req_r == cdq_pkg::REQ_INS_REAR);
  assign front = (req_r == cdq_pkg::REQ_INS_FRONT) || (req_r == cdq_pkg::REQ_DEL_FRONT);
  assign full  = !empty && (wrap_inc(tail) == head);
  assign succ  = ins ? !full : !empty;

  assign sts.is_insert = ins;
  assign sts.full      = full;
  assign sts.empty     = empty;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    if (ins) begin
      if (empty) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
      end else if (front) begin
        head_next = wrap_dec(head);
      end else begin
        tail_next = wrap_inc(tail);
      end
    end else begin
      if (head == tail) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (front) begin
        head_next = wrap_inc(head);
      end else begin
        tail_next = wrap_dec(tail);
      end
    end
  end

  assign head_eff  = succ ? head_next : head;
  assign tail_eff  = succ ? tail_next : tail;
  assign empty_eff = succ ? empty_next : empty;

  assign waddr = empty ? '0 : (front ? head_next : tail_next);
  assign raddr = front ? head : tail;

  cdq_ram #(
    .WIDTH(cdq_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.do_write),
    .waddr(waddr),
    .wdata(value_r),
    .re   (cmd.do_read),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else if (cmd.upd_ptr) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= req_type;
      value_r <= value;
    end
    if (cmd.load_out) begin
      if (ins) begin
        status <= full ? cdq_pkg::STAT_REJ_FULL : cdq_pkg::STAT_DONE;
      end else begin
        status <= empty ? cdq_pkg::STAT_REJ_EMPTY : cdq_pkg::STAT_DONE;
      end
      removed_value <= (!ins && !empty) ? rdata : '0;
      is_empty      <= empty_eff;
      is_full       <= !empty_eff && (wrap_inc(tail_eff) == head_eff);
    end
  end

endmodule

### rtl/circular_deque_engine_unit.sv
// Channel  Handshake             Payload
// req      req_valid/req_ready   req_type, value
// rsp      rsp_valid/rsp_ready   status, removed_value, is_empty, is_full
//
// Insert: execute loads the result; only one request is in flight at a time.
// Delete: execute, then read loads the result (an empty deque is rejected
// from execute); the extra step is the registered read of the slot RAM.
// A result waits in the output register; the next request is taken meanwhile
// and holds in execute or read until the output register frees.
// rst (synchronous) empties the deque; slot contents are not cleared.
module circular_deque_engine_unit #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [cdq_pkg::REQ_W-1:0]         req_type,
  input  logic signed [cdq_pkg::WORD_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [cdq_pkg::STAT_W-1:0]        status,
  output logic signed [cdq_pkg::WORD_W-1:0] removed_value,
  output logic                              is_empty,
  output logic                              is_full
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .value        (value),
    .status       (status),
    .removed_value(removed_value),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule

### rtl/cdq_chk.sv
module cdq_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [cdq_pkg::STAT_W-1:0]        status,
  input logic signed [cdq_pkg::WORD_W-1:0] removed_value,
  input logic                              is_empty,
  input logic                              is_full
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(removed_value))
    else $error("rsp changed while stalled");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one in flight");

  a_rej_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cdq_pkg::STAT_REJ_FULL |->
      is_full && !is_empty && removed_value == '0)
    else $error("full reject with bad flags");

  a_rej_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cdq_pkg::STAT_REJ_EMPTY |->
      is_empty && !is_full && removed_value == '0)
    else $error("empty reject with bad flags");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(is_empty && is_full))
    else $error("empty and full together");

endmodule

bind circular_deque_engine_unit cdq_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .status       (status),
  .removed_value(removed_value),
  .is_empty     (is_empty),
  .is_full      (is_full)
);
